### hdl/brm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the block RMS meter.
// No dependencies; every other file in hdl imports this package.
package brm_pkg;

  localparam int SAMPLE_W      = 24;            // input sample width, Q1.23
  localparam int SAMPLE_BITS   = 24;            // significant top bits of a sample
  localparam int LEVEL_W       = 24;            // RMS level width, unsigned Q1.23
  localparam int MEAN_W        = 2 * LEVEL_W;   // mean of squares, Q2.46
  localparam int SQRT_STEPS    = MEAN_W / 2;    // one result bit per step
  localparam int MAX_BLOCK_DEF = 4096;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DIV,
    ST_SQRT,
    ST_EMIT
  } brm_state_e;

  typedef enum logic {
    OP_ADD,
    OP_SUB
  } brm_op_e;

  // sequencer -> datapath
  typedef struct packed {
    logic take;       // ready for an input beat
    logic accum;      // add the latched square
    logic div;        // one restoring divide step
    logic sqrt;       // one square root step
    logic emit_load;  // move the level into the output register
    logic last_step;  // final iteration of divide or square root
  } brm_ctrl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic in_valid;
    logic last;       // latched last_in_block of the current beat
    logic out_free;   // output register empty or draining this cycle
  } brm_stat_t;

endpackage

### hdl/brm_alu.sv
`timescale 1ns / 1ps
// Shared add / subtract-compare unit of the RMS meter.
// Depends on brm_pkg for the operation code.
module brm_alu #(
  parameter int W = 59
) (
  input  logic [W-1:0]     a_i,
  input  logic [W-1:0]     b_i,
  input  brm_pkg::brm_op_e op_i,
  output logic [W-1:0]     res_o,
  output logic             ge_o
);
  import brm_pkg::*;

  logic         sub;
  logic [W-1:0] b_x;
  logic [W:0]   full;

  assign sub   = (op_i == OP_SUB);
  assign b_x   = sub ? ~b_i : b_i;
  assign full  = {1'b0, a_i} + {1'b0, b_x} + {{W{1'b0}}, sub};
  assign res_o = full[W-1:0];
  // carry out of a - b means a >= b
  assign ge_o  = full[W];

endmodule

### hdl/brm_seq.sv
`timescale 1ns / 1ps
// Sequencer of the RMS meter: state machine and iteration counter.
// Depends on brm_pkg for the state enum and control structs.
module brm_seq #(
  parameter int SUM_W = 59
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  brm_pkg::brm_stat_t  stat_i,
  output brm_pkg::brm_ctrl_t  ctrl_o
);
  import brm_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  brm_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              last_step;

  assign last_step = (step_q == '0);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (stat_i.in_valid) state_d = ST_ACCUM;
      end
      ST_ACCUM: begin
        step_d = STEP_W'(SUM_W - 1);
        state_d = stat_i.last ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (last_step) begin
          state_d = ST_SQRT;
          step_d  = STEP_W'(SQRT_STEPS - 1);
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_SQRT: begin
        if (last_step) state_d = ST_EMIT;
        else step_d = step_q - 1'b1;
      end
      ST_EMIT: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o           = '0;
    ctrl_o.last_step = last_step;
    unique case (state_q)
      ST_IDLE:  ctrl_o.take      = 1'b1;
      ST_ACCUM: ctrl_o.accum     = 1'b1;
      ST_DIV:   ctrl_o.div       = 1'b1;
      ST_SQRT:  ctrl_o.sqrt      = 1'b1;
      ST_EMIT:  ctrl_o.emit_load = stat_i.out_free;
      default:  ctrl_o.take      = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

### hdl/block_rms_meter_unit.sv
`timescale 1ns / 1ps
// Block RMS meter: top level with the sample datapath and result register.
// Depends on brm_pkg, brm_alu and brm_seq.
//
// Each sample beat is accepted and squared in the idle state, and its square is
// then added into the exact accumulator through the shared adder. A beat flagged
// last_in_block is followed by a restoring divide (one quotient bit per cycle,
// 47 + clog2(MAX_BLOCK) quotient bits, 59 at the default) and a digit-by-digit
// square root of 24 result bits, both on the same shared add/compare unit, and
// then the level is loaded into the output register. The output register holds
// the level while new samples are accepted; the next block end waits there only
// if that result has not yet been taken. Samples beyond MAX_BLOCK in one block
// are dropped and flagged in block_overflow.
module block_rms_meter_unit #(
  parameter int MAX_BLOCK = brm_pkg::MAX_BLOCK_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [brm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                          last_in_block_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [brm_pkg::LEVEL_W-1:0]   rms_level_o,
  output logic                          block_overflow_o
);
  import brm_pkg::*;

  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W = 2 * SAMPLE_W - 1 + $clog2(MAX_BLOCK);
  localparam logic [SAMPLE_W-1:0] KeepMask = {SAMPLE_W{1'b1}} << (SAMPLE_W - SAMPLE_BITS);
  localparam logic [CNT_W-1:0]    MaxCnt   = CNT_W'(MAX_BLOCK);

  brm_ctrl_t ctrl;
  brm_stat_t stat;

  logic [SAMPLE_W-1:0] kept, mag;
  logic [MEAN_W-1:0]   square;

  logic [MEAN_W-1:0]   sq_q, sq_d;
  logic                last_q, last_d;
  logic [SUM_W-1:0]    acc_q, acc_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                ovf_q, ovf_d;
  logic [CNT_W:0]      div_rem_q, div_rem_d, div_trial;
  logic [MEAN_W-1:0]   v_q, v_d;
  logic [LEVEL_W+1:0]  sq_rem_q, sq_rem_d, sq_trial;
  logic [LEVEL_W-1:0]  root_q, root_d;
  logic                out_valid_q, out_valid_d;
  logic [LEVEL_W-1:0]  out_level_q, out_level_d;
  logic                out_ovf_q, out_ovf_d;

  logic [SUM_W-1:0]    alu_a, alu_b, alu_res;
  brm_op_e             alu_op;
  logic                alu_ge;

  // magnitude of the truncated sample; -1.0 maps to 2^23
  assign kept   = sample_i & KeepMask;
  assign mag    = kept[SAMPLE_W-1] ? (~kept + 1'b1) : kept;
  assign square = mag * mag;

  assign div_trial = {div_rem_q[CNT_W-1:0], acc_q[SUM_W-1]};
  assign sq_trial  = {sq_rem_q[LEVEL_W-1:0], v_q[MEAN_W-1 -: 2]};

  assign stat.in_valid = in_valid_i;
  assign stat.last     = last_q;
  assign stat.out_free = !out_valid_q || out_ready_i;

  brm_seq #(
    .SUM_W(SUM_W)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  always_comb begin
    alu_a  = '0;
    alu_b  = '0;
    alu_op = OP_ADD;
    priority if (ctrl.accum) begin
      alu_a = acc_q;
      alu_b = SUM_W'(sq_q);
    end else if (ctrl.div) begin
      alu_a  = SUM_W'(div_trial);
      alu_b  = SUM_W'(cnt_q);
      alu_op = OP_SUB;
    end else if (ctrl.sqrt) begin
      alu_a  = SUM_W'(sq_trial);
      alu_b  = SUM_W'({root_q, 2'b01});
      alu_op = OP_SUB;
    end
  end

  brm_alu #(
    .W(SUM_W)
  ) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .op_i  (alu_op),
    .res_o (alu_res),
    .ge_o  (alu_ge)
  );

  always_comb begin
    sq_d        = sq_q;
    last_d      = last_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    div_rem_d   = div_rem_q;
    v_d         = v_q;
    sq_rem_d    = sq_rem_q;
    root_d      = root_q;
    out_level_d = out_level_q;
    out_ovf_d   = out_ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (ctrl.take && in_valid_i) begin
      sq_d   = square;
      last_d = last_in_block_i;
    end

    if (ctrl.accum) begin
      if (cnt_q < MaxCnt) begin
        acc_d = alu_res;
        cnt_d = cnt_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
      div_rem_d = '0;
    end

    if (ctrl.div) begin
      div_rem_d = alu_ge ? alu_res[CNT_W:0] : div_trial;
      acc_d     = {acc_q[SUM_W-2:0], alu_ge};
      if (ctrl.last_step) begin
        // quotient complete: seed the square root
        v_d      = (cnt_q == '0) ? '0 : MEAN_W'(acc_d);
        sq_rem_d = '0;
        root_d   = '0;
      end
    end

    if (ctrl.sqrt) begin
      sq_rem_d = alu_ge ? alu_res[LEVEL_W+1:0] : sq_trial;
      root_d   = {root_q[LEVEL_W-2:0], alu_ge};
      v_d      = v_q << 2;
    end

    if (ctrl.emit_load) begin
      out_level_d = root_q;
      out_ovf_d   = ovf_q;
      out_valid_d = 1'b1;
      acc_d       = '0;
      cnt_d       = '0;
      ovf_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q        <= sq_d;
    div_rem_q   <= div_rem_d;
    v_q         <= v_d;
    sq_rem_q    <= sq_rem_d;
    root_q      <= root_d;
    out_level_q <= out_level_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign in_ready_o       = ctrl.take;
  assign out_valid_o      = out_valid_q;
  assign rms_level_o      = out_level_q;
  assign block_overflow_o = out_ovf_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt)
    else $error("sample count ran past the block limit");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (cnt_q == MaxCnt))
    else $error("overflow flagged before the block filled");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rms_level_o <= LEVEL_W'(24'h800000)))
    else $error("level above full scale");

  a_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_in_block_i) |=> !in_ready_o)
    else $error("input taken while the block result is still in work");

endmodule
